### sv/fsd_pkg.sv
// shared types and constants for the floyd-steinberg grey dither block
// no dependencies; imported by the stream interfaces and the top level
package fsd_pkg;

    // payload and register widths
    localparam int PIX_W     = 8;
    localparam int THR_W     = 8;
    localparam int IMG_W_W   = 12;
    localparam int IMG_H_W   = 13;
    localparam int ROW_W     = 12;
    localparam int ERR_W     = 16;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // limits and reset values
    localparam int MAX_HEIGHT    = 4096;
    localparam int THR_RESET     = 128;
    localparam int IMG_W_RESET   = 640;
    localparam int IMG_H_RESET   = 480;
    localparam logic [PIX_W-1:0] DOT_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] DOT_BLACK = 8'd0;

    // register map, one 32-bit word per register
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

endpackage

### sv/fsd_pix_if.sv
// input stream interface: one grey pixel per item
// depends on fsd_pkg
interface fsd_pix_if
    import fsd_pkg::*;
();
    logic valid;
    logic ready;
    t_pix pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

### sv/fsd_dot_if.sv
// output stream interface: one dithered dot with line and frame markers per item
// depends on fsd_pkg
interface fsd_dot_if
    import fsd_pkg::*;
();
    logic valid;
    logic ready;
    t_pix dot_out;
    logic end_of_line;
    logic end_of_frame;

    modport source (output valid, output dot_out, output end_of_line, output end_of_frame,
                    input ready);
    modport sink   (input valid, input dot_out, input end_of_line, input end_of_frame,
                    output ready);
endinterface

### sv/floyd_steinberg_gray_dither.sv
// floyd-steinberg error diffusion of an 8-bit grey raster stream to 0 / 255 dots
// a pixel passes the input stage (stage 1), then the result register, on its way to result valid;
// throughput: one item per cycle unless o_dot.ready holds the output back, set by the loop add
// error, threshold, 7/16 share, back to the right carry
// reset (synchronous, active low) clears position, carries and registers to defaults;
// the line store is not cleared, row 0 never reads it, so no clearing pass is needed
// depends on fsd_pkg, fsd_pix_if, fsd_dot_if, fsd_ram
module floyd_steinberg_gray_dither
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH     = 2048,
    parameter int FRACTION_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fsd_pix_if.sink           i_pix,
    fsd_dot_if.source         o_dot,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam int FB   = FRACTION_BITS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int MWW  = $clog2(MAX_WIDTH + 1);
    localparam int WCW  = ((MWW > IMG_W_W) ? MWW : IMG_W_W) + 1;
    localparam int HCW  = IMG_H_W + 1;
    localparam int VW   = (((FB + 9) > (ERR_W + 1)) ? (FB + 9) : (ERR_W + 1)) + 1;
    localparam int EW   = VW + 1;
    localparam int PW   = EW + 3;
    localparam int WHITE_FX = 255 * (2 ** FB);
    localparam int ERR_MAX  = (2 ** (ERR_W - 1)) - 1;
    localparam int ERR_MIN  = -(2 ** (ERR_W - 1));

    // clamp a wide signed value to the stored error range
    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [PW-1:0] v);
        logic signed [ERR_W-1:0] res;
        if (v > PW'(ERR_MAX)) begin
            res = ERR_W'(ERR_MAX);
        end else if (v < PW'(ERR_MIN)) begin
            res = ERR_W'(ERR_MIN);
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

    // configuration registers
    logic [THR_W-1:0]   r_thr;
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;

    // position counters at the input side
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // stage 1: accepted pixel waiting for its line store word
    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic             r_s1_row_nz;
    logic             r_s1_eol;
    logic             r_s1_eof;
    logic             r_fwd_valid;
    logic [ERR_W-1:0] r_fwd_data;

    // diffusion state
    logic signed [ERR_W-1:0] r_rc;
    logic signed [ERR_W-1:0] r_bp;
    logic signed [ERR_W-1:0] r_brp;

    // deferred end-of-line write into the line store
    logic             r_dw_valid;
    logic [CW-1:0]    r_dw_addr;
    logic [ERR_W-1:0] r_dw_data;

    // output register
    logic r_out_valid;
    t_pix r_out_dot;
    logic r_out_eol;
    logic r_out_eof;

    logic             acc;
    logic             s1_go;
    logic             out_free;
    logic [WCW-1:0]   w_ext;
    logic [WCW-1:0]   w_eff;
    logic [HCW-1:0]   h_eff;
    logic             eol_acc;
    logic             eof_acc;
    logic [ERR_W-1:0] ram_rdata;
    logic             mem_we;
    logic [CW-1:0]    mem_waddr;
    logic [ERR_W-1:0] mem_wdata;
    logic [CW-1:0]    s1_addr_n;
    logic             cfg_we;

    logic signed [ERR_W-1:0] nre;
    logic signed [VW-1:0]    v;
    logic signed [VW-1:0]    thr_fx;
    logic                    white;
    logic signed [EW-1:0]    e;
    logic signed [PW-1:0]    ep;
    logic signed [PW-1:0]    s7;
    logic signed [PW-1:0]    s3;
    logic signed [PW-1:0]    s5;
    logic signed [PW-1:0]    s1;
    logic signed [ERR_W-1:0] wr_left;
    logic signed [ERR_W-1:0] bp_n;
    logic signed [ERR_W-1:0] brp_n;

    // handshake: the output register frees stage 1, stage 1 frees the input
    assign out_free    = !r_out_valid || o_dot.ready;
    assign s1_go       = r_s1_valid && out_free;
    assign i_pix.ready = !r_s1_valid || out_free;
    assign acc         = i_pix.valid && i_pix.ready;

    assign o_dot.valid        = r_out_valid;
    assign o_dot.dot_out      = r_out_dot;
    assign o_dot.end_of_line  = r_out_eol;
    assign o_dot.end_of_frame = r_out_eof;

    // apb port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_THRESHOLD: prdata = APB_DW'(r_thr);
            REG_WIDTH:     prdata = APB_DW'(r_img_w);
            REG_HEIGHT:    prdata = APB_DW'(r_img_h);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_W'(THR_RESET);
            r_img_w <= IMG_W_W'(IMG_W_RESET);
            r_img_h <= IMG_H_W'(IMG_H_RESET);
        end else if (cfg_we) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_THRESHOLD: r_thr   <= pwdata[THR_W-1:0];
                REG_WIDTH:     r_img_w <= pwdata[IMG_W_W-1:0];
                REG_HEIGHT:    r_img_h <= pwdata[IMG_H_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective frame size, zero taken as one and large values saturated
    always_comb begin
        w_ext = WCW'(r_img_w);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_img_h == '0) begin
            h_eff = HCW'(1);
        end else if (HCW'(r_img_h) > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = HCW'(r_img_h);
        end
    end

    assign eol_acc = (WCW'(r_col) + WCW'(1)) >= w_eff;
    assign eof_acc = eol_acc && ((HCW'(r_row) + HCW'(1)) >= h_eff);

    // line store of errors for the next row, read when the item is accepted
    fsd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // one write per cycle: the end-of-line write is deferred, the next item is column 0
    always_comb begin
        mem_we    = r_dw_valid || (s1_go && (r_s1_col != '0));
        mem_waddr = r_dw_valid ? r_dw_addr : (r_s1_col - CW'(1));
        mem_wdata = r_dw_valid ? r_dw_data : wr_left;
    end

    assign s1_addr_n = acc ? r_col : r_s1_col;

    // error arithmetic for the item in stage 1
    always_comb begin
        if (!r_s1_row_nz) begin
            nre = '0;
        end else if (r_dw_valid && (r_dw_addr == r_s1_col)) begin
            // one-pixel rows: the deferred word of the row above lands this cycle
            nre = r_dw_data;
        end else if (r_fwd_valid) begin
            nre = r_fwd_data;
        end else begin
            nre = ram_rdata;
        end
        v = $signed({{(VW - PIX_W - FB){1'b0}}, r_s1_pix, {FB{1'b0}}})
            + VW'(r_rc) + VW'(nre);
        thr_fx = $signed({{(VW - THR_W - FB){1'b0}}, r_thr, {FB{1'b0}}});
        white  = v > thr_fx;
        e      = EW'(v) - (white ? EW'(WHITE_FX) : EW'(0));
        ep     = PW'(e);
        s7     = ((ep <<< 3) - ep) >>> 4;
        s3     = ((ep <<< 1) + ep) >>> 4;
        s5     = ((ep <<< 2) + ep) >>> 4;
        s1     = ep >>> 4;
        wr_left = sat_err(PW'(r_bp) + s3);
        bp_n    = sat_err(PW'(r_brp) + s5);
        brp_n   = sat_err(s1);
    end

    // position counters and stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (eol_acc) begin
                    r_col <= '0;
                    r_row <= eof_acc ? '0 : (r_row + ROW_W'(1));
                end else begin
                    r_col <= r_col + CW'(1);
                end
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            // keep the stage 1 word current with writes landing after the read
            if (mem_we && (mem_waddr == s1_addr_n)) begin
                r_fwd_valid <= 1'b1;
            end else if (acc) begin
                r_fwd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix    <= i_pix.pixel_in;
            r_s1_col    <= r_col;
            r_s1_row_nz <= r_row != '0;
            r_s1_eol    <= eol_acc;
            r_s1_eof    <= eof_acc;
        end
        if (mem_we && (mem_waddr == s1_addr_n)) begin
            r_fwd_data <= mem_wdata;
        end
    end

    // diffusion state and deferred write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc       <= '0;
            r_bp       <= '0;
            r_brp      <= '0;
            r_dw_valid <= 1'b0;
        end else begin
            r_dw_valid <= s1_go && r_s1_eol;
            if (s1_go) begin
                if (r_s1_eol) begin
                    r_rc  <= '0;
                    r_bp  <= '0;
                    r_brp <= '0;
                end else begin
                    r_rc  <= sat_err(s7);
                    r_bp  <= bp_n;
                    r_brp <= brp_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_dw_addr <= r_s1_col;
            r_dw_data <= bp_n;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_dot.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_dot <= white ? DOT_WHITE : DOT_BLACK;
            r_out_eol <= r_s1_eol;
            r_out_eof <= r_s1_eof;
        end
    end

endmodule

### sv/fsd_ram.sv
// generic simple dual-port ram, one write and one read port, registered read
// read returns the old word when the same address is written in that cycle
module fsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### tb/sv/testbench.sv
// testbench for floyd_steinberg_gray_dither: a directed table, then random pixel frames
// checks every dot against an in-bench error diffusion predictor, or against the typed dot of a table row
// depends on fsd_pkg, fsd_pix_if, fsd_dot_if and the dither rtl
`timescale 1ns / 100ps

module testbench;
    import fsd_pkg::*;

    localparam int LINE_MAX    = 2048;
    localparam int FRAC        = 4;
    localparam int FULL_SCALE  = 255 << FRAC;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        t_pix dot;
        logic eol;
        logic eof;
    } dot_t;

    // one row of the directed table: a register write or a pixel
    typedef struct {
        bit          cfg;
        t_reg_idx    reg_sel;
        int unsigned value;
        t_pix        pix;
        bit          typed;
        dot_t        want;
    } step_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    fsd_pix_if pix_if ();
    fsd_dot_if dot_if ();

    floyd_steinberg_gray_dither dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_dot   (dot_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of registers and diffusion state
    logic [THR_W-1:0]        thr_reg    = THR_RESET;
    logic [IMG_W_W-1:0]      width_reg  = IMG_W_RESET;
    logic [IMG_H_W-1:0]      height_reg = IMG_H_RESET;
    logic signed [ERR_W-1:0] line_err [LINE_MAX];
    logic signed [ERR_W-1:0] carry_right      = '0;
    logic signed [ERR_W-1:0] pend_below       = '0;
    logic signed [ERR_W-1:0] pend_below_right = '0;
    int col_pos      = 0;
    int row_pos      = 0;
    int written_upto = 0;   // line store entries [0, written_upto) hold data

    dot_t pending_dots [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle      = 0;
    int   recv_stall     = 0;
    int   hold_asked     = 0;
    int   hold_served    = 0;
    int   hold_left      = 0;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic signed [ERR_W-1:0] sat_err(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return ERR_W'(v);
    endfunction

    function automatic int eff_width(int raw);
        if (raw == 0) return 1;
        return (raw > LINE_MAX) ? LINE_MAX : raw;
    endfunction

    // one pixel through the diffusion, updating the predictor state
    function automatic dot_t diffuse_pixel(t_pix p);
        int w, h, c, v, e, s7, s3, s5, s1;
        bit white, eol, eof;
        w = eff_width(int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        eol = (c + 1 >= w);
        eof = eol && (row_pos + 1 >= h);
        v = (int'(p) << FRAC) + int'(carry_right);
        if (row_pos > 0) v += int'(line_err[c]);
        white = (v > (int'(thr_reg) << FRAC));
        e = white ? v - FULL_SCALE : v;
        // arithmetic shift gives the floored sixteenths
        s7 = (e * 7) >>> FRAC;
        s3 = (e * 3) >>> FRAC;
        s5 = (e * 5) >>> FRAC;
        s1 = e >>> FRAC;
        if (c > 0) line_err[c-1] = sat_err(int'(pend_below) + s3);
        pend_below       = sat_err(int'(pend_below_right) + s5);
        pend_below_right = sat_err(s1);
        if (eol) begin
            line_err[c]      = pend_below;
            carry_right      = '0;
            pend_below       = '0;
            pend_below_right = '0;
            col_pos          = 0;
            row_pos          = eof ? 0 : row_pos + 1;
            if (c + 1 > written_upto) written_upto = c + 1;
        end else begin
            carry_right = sat_err(s7);
            col_pos     = c + 1;
            if (c > written_upto) written_upto = c;
        end
        return dot_t'{white ? DOT_WHITE : DOT_BLACK, eol, eof};
    endfunction

    function automatic step_t pix_step(t_pix p);
        step_t s;
        s = '{reg_sel: REG_THRESHOLD, default: '0};
        s.pix = p;
        return s;
    endfunction

    function automatic step_t typed_step(t_pix p, dot_t d);
        step_t s;
        s = '{reg_sel: REG_THRESHOLD, default: '0};
        s.pix   = p;
        s.typed = 1'b1;
        s.want  = d;
        return s;
    endfunction

    function automatic step_t cfg_step(t_reg_idx idx, int unsigned value);
        step_t s;
        s = '{reg_sel: REG_THRESHOLD, default: '0};
        s.cfg     = 1'b1;
        s.reg_sel = idx;
        s.value   = value;
        return s;
    endfunction

    // apb write: setup, then access until pready
    task automatic write_reg(t_reg_idx idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_reg = value[THR_W-1:0];
            REG_WIDTH:     width_reg = value[IMG_W_W-1:0];
            REG_HEIGHT:    height_reg = value[IMG_H_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // offer one pixel item with random idle gaps, predict once accepted
    task automatic send_pixel(t_pix p, bit typed, dot_t typed_dot);
        dot_t got;
        while ($urandom_range(99) < send_idle) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= p;
        do @(posedge i_clk); while (!pix_if.ready);
        got = diffuse_pixel(p);
        pending_dots.push_back(typed ? typed_dot : got);
    endtask

    // stop offering and wait until every dot has come back
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        while (pending_dots.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // reconfigure while idle, then stream random pixels
    task automatic run_phase(int thr, int wraw, int hraw, int n, int sidle, int rstall,
                             bit hold, bit pause, bit align);
        dot_t none;
        t_pix p;
        int   i;
        none = '0;
        drain_results();
        // a wider row mid-frame must only reach line store entries already written
        if (row_pos != 0 && eff_width(wraw) > written_upto) wraw = written_upto;
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WIDTH, wraw);
        write_reg(REG_HEIGHT, hraw);
        send_idle  = sidle;
        recv_stall = rstall;
        if (hold) hold_asked++;
        i = 0;
        while (i < n || (align && (row_pos != 0 || col_pos != 0))) begin
            if (pause && i == n / 2) begin
                pix_if.valid <= 1'b0;
                do @(posedge i_clk); while (pending_dots.size() != 0);
            end
            case ($urandom_range(7))
                0:       p = 8'd0;
                1:       p = 8'd255;
                default: p = t_pix'($urandom_range(255));
            endcase
            send_pixel(p, 1'b0, none);
            i++;
        end
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            dot_if.ready <= 1'b0;
        end else begin
            dot_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // compare each accepted dot with the oldest expectation
    always @(posedge i_clk) begin : check_dots
        dot_t want;
        if (i_rst_n && dot_if.valid && dot_if.ready) begin
            if (pending_dots.size() == 0) begin
                $display("%0t: unexpected item: expected none, got dot %0d eol %0b eof %0b",
                         $time, dot_if.dot_out, dot_if.end_of_line, dot_if.end_of_frame);
                mismatch_count++;
            end else begin
                want = pending_dots.pop_front();
                if (dot_if.dot_out !== want.dot) begin
                    $display("%0t: dot_out expected %0d got %0d",
                             $time, want.dot, dot_if.dot_out);
                    mismatch_count++;
                end
                if (dot_if.end_of_line !== want.eol) begin
                    $display("%0t: end_of_line expected %0b got %0b",
                             $time, want.eol, dot_if.end_of_line);
                    mismatch_count++;
                end
                if (dot_if.end_of_frame !== want.eof) begin
                    $display("%0t: end_of_frame expected %0b got %0b",
                             $time, want.eof, dot_if.end_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // main sequence
    initial begin
        step_t plan [$];
        int    idle_pct [4];
        int    stall_pct [4];
        int    k, thr, wraw, hraw;
        idle_pct  = '{0, 53, 0, 9};
        stall_pct = '{0, 0, 53, 9};
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        pix_if.valid    <= 1'b0;
        pix_if.pixel_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: white at full scale, strict threshold at 128
        plan.push_back(typed_step(8'd255, dot_t'{DOT_WHITE, 1'b0, 1'b0}));
        plan.push_back(typed_step(8'd0, dot_t'{DOT_BLACK, 1'b0, 1'b0}));
        plan.push_back(typed_step(8'd128, dot_t'{DOT_BLACK, 1'b0, 1'b0}));
        plan.push_back(pix_step(8'd0));
        plan.push_back(pix_step(8'd129));
        // shrink mid-row: column already past the new width ends the row
        plan.push_back(cfg_step(REG_THRESHOLD, 0));
        plan.push_back(cfg_step(REG_WIDTH, 3));
        plan.push_back(cfg_step(REG_HEIGHT, 2));
        plan.push_back(pix_step(8'd200));
        plan.push_back(pix_step(8'd17));
        plan.push_back(pix_step(8'd240));
        plan.push_back(pix_step(8'd90));
        // top threshold: even full scale stays black with no carried error
        plan.push_back(cfg_step(REG_THRESHOLD, 255));
        plan.push_back(typed_step(8'd255, dot_t'{DOT_BLACK, 1'b0, 1'b0}));
        plan.push_back(pix_step(8'd255));
        // zero width and height behave as one
        plan.push_back(cfg_step(REG_THRESHOLD, 0));
        plan.push_back(cfg_step(REG_WIDTH, 0));
        plan.push_back(cfg_step(REG_HEIGHT, 0));
        plan.push_back(pix_step(8'd0));
        plan.push_back(typed_step(8'd0, dot_t'{DOT_BLACK, 1'b1, 1'b1}));
        plan.push_back(typed_step(8'd1, dot_t'{DOT_WHITE, 1'b1, 1'b1}));
        plan.push_back(typed_step(8'd255, dot_t'{DOT_WHITE, 1'b1, 1'b1}));
        plan.push_back(cfg_step(REG_THRESHOLD, 255));
        plan.push_back(typed_step(8'd255, dot_t'{DOT_BLACK, 1'b1, 1'b1}));
        // one-pixel rows exercise the line store on a single column
        plan.push_back(cfg_step(REG_THRESHOLD, 128));
        plan.push_back(cfg_step(REG_WIDTH, 1));
        plan.push_back(cfg_step(REG_HEIGHT, 3));
        plan.push_back(pix_step(8'd100));
        plan.push_back(pix_step(8'd140));
        plan.push_back(pix_step(8'd127));
        plan.push_back(pix_step(8'd255));

        foreach (plan[j]) begin
            if (plan[j].cfg) begin
                drain_results();
                write_reg(plan[j].reg_sel, plan[j].value);
            end else begin
                send_pixel(plan[j].pix, plan[j].typed, plan[j].want);
            end
        end

        // random frames over the idling modes, with a hold-off and a pause
        for (k = 0; k < 13; k++) begin
            thr = (k == 1) ? 0 : ((k == 2) ? 255 : $urandom_range(255));
            case ($urandom_range(9))
                0:       wraw = 0;
                1:       wraw = $urandom_range(300, 64);
                default: wraw = $urandom_range(24, 1);
            endcase
            hraw = ($urandom_range(7) == 0) ? 0 : $urandom_range(6, 1);
            run_phase(thr, wraw, hraw, 170, idle_pct[k % 4], stall_pct[k % 4],
                      k == 4, k == 6, 1'b0);
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
